// ----- sv/serial_line_editor_top_assert.svh -----
// Assertion macros used by the line editor RTL.
`ifndef SERIAL_LINE_EDITOR_TOP_ASSERT_SVH
`define SERIAL_LINE_EDITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SLE_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SLE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sle_pkg.sv -----
`default_nettype none

package sle_pkg;

  typedef logic [7:0] byte_t;

  localparam int LEN_W       = 6;

  localparam byte_t CH_BS    = 8'h08;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TILDE = 8'h7E;
  localparam byte_t CH_DEL   = 8'h7F;
  localparam byte_t CH_NUL   = 8'h00;

endpackage

`default_nettype wire

// ----- sv/sle_store.sv -----
`default_nettype none

// Line store: one write port, one read port, registered read data.
// Entries never written since reset read as zero through per-entry valid bits.
module sle_store #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire sle_pkg::byte_t wr_data,
  input  wire logic [AW-1:0]  rd_addr,
  output sle_pkg::byte_t      rd_data
);

  sle_pkg::byte_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  sle_pkg::byte_t   rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rvld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : sle_pkg::CH_NUL;

endmodule

`default_nettype wire

// ----- sv/serial_line_editor_top.sv -----
`default_nettype none

// Channel   Dir  Ports                         Contents
// in        in   in_tvalid/in_tready/in_tdata  [7:0] rx_byte
// out       out  out_tvalid/out_tready/        [7:0] echo_char, [8] line_done,
//                out_tdata/out_tlast           [14:9] line_length; tlast = last
//
// One request is taken while the sequencer is idle; results drain through a
// single output register, so a new byte can enter while the last result waits.
// Printable: echo. Erase: BS, space, BS. CR/LF: CR, LF. Tab replay: one
// stored byte per unstalled cycle via the store's single read port, then LF.
// Reset clears the cursor and the store's valid bits at once; no clearing pass.
// A stalled output holds the sequencer in place.
module serial_line_editor_top #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] echo_char, [8] line_done, [14:9] line_length
  output logic             out_tlast
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW:0]   CAP_W    = (AW+1)'(LINE_CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_CAPACITY - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRINT  = 3'd1;
  localparam logic [2:0] S_ERASE  = 3'd2;
  localparam logic [2:0] S_NEWLN  = 3'd3;
  localparam logic [2:0] S_REPLAY = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [AW-1:0]  cursor_r, cursor_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]     step_r, step_nxt;
  sle_pkg::byte_t ch_r, ch_nxt;

  logic           out_valid_r;
  sle_pkg::byte_t out_char_r;
  logic           out_done_r;
  logic [sle_pkg::LEN_W-1:0] out_len_r;
  logic           out_last_r;

  logic           out_free;
  logic           emit;
  sle_pkg::byte_t e_char;
  logic           e_done;
  logic [sle_pkg::LEN_W-1:0] e_len;
  logic           e_last;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  sle_pkg::byte_t wr_data;
  logic [AW-1:0]  rd_addr;
  sle_pkg::byte_t rd_data;

  logic [AW+sle_pkg::LEN_W-1:0] cnt_ext;
  sle_pkg::byte_t in_byte;
  logic           in_acc;

  assign in_byte  = in_tdata[7:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_ext  = {{sle_pkg::LEN_W{1'b0}}, cnt_r};

  sle_store #(
    .DEPTH(LINE_CAPACITY)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    ch_nxt     = ch_r;
    wr_en      = 1'b0;
    wr_addr    = cursor_r;
    wr_data    = in_byte;
    rd_addr    = cnt_r;
    emit       = 1'b0;
    e_char     = sle_pkg::CH_LF;
    e_done     = 1'b0;
    e_len      = '0;
    e_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_nxt = in_byte;
          case (in_byte) inside
            sle_pkg::CH_TAB: begin
              if (cursor_r == '0) begin
                cnt_nxt   = '0;
                state_nxt = S_REPLAY;
              end
            end
            sle_pkg::CH_BS, sle_pkg::CH_DEL: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                step_nxt   = 2'd0;
                state_nxt  = S_ERASE;
              end
            end
            sle_pkg::CH_CR, sle_pkg::CH_LF: begin
              wr_en      = 1'b1;
              wr_data    = sle_pkg::CH_NUL;
              cnt_nxt    = cursor_r;  // line length held for the LF result
              cursor_nxt = '0;
              step_nxt   = 2'd0;
              state_nxt  = S_NEWLN;
            end
            [sle_pkg::CH_SPACE:sle_pkg::CH_TILDE]: begin
              if (({1'b0, cursor_r} + 1'b1) < CAP_W) begin
                wr_en      = 1'b1;
                cursor_nxt = cursor_r + 1'b1;
                state_nxt  = S_PRINT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PRINT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_char    = ch_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_ERASE: begin
        if (out_free) begin
          emit     = 1'b1;
          e_char   = (step_r == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
          e_last   = (step_r == 2'd2);
          step_nxt = step_r + 1'b1;
          if (step_r == 2'd2) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_NEWLN: begin
        if (out_free) begin
          emit = 1'b1;
          if (step_r == 2'd0) begin
            e_char   = sle_pkg::CH_CR;
            step_nxt = 2'd1;
          end else begin
            e_char    = sle_pkg::CH_LF;
            e_done    = 1'b1;
            e_len     = cnt_ext[sle_pkg::LEN_W-1:0];
            e_last    = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      S_REPLAY: begin
        // rd_data holds entry cnt_r; the next address is fetched as a byte goes out
        if (out_free) begin
          emit = 1'b1;
          if (rd_data != sle_pkg::CH_NUL && cnt_r != LAST_IDX) begin
            e_char  = rd_data;
            cnt_nxt = cnt_r + 1'b1;
            rd_addr = cnt_r + 1'b1;
          end else begin
            e_char    = sle_pkg::CH_LF;
            e_done    = (cnt_r != '0);
            e_len     = cnt_ext[sle_pkg::LEN_W-1:0];
            e_last    = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      cnt_r       <= '0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
      step_r   <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    if (emit) begin
      out_char_r <= e_char;
      out_done_r <= e_done;
      out_len_r  <= e_len;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_done_r, out_char_r};
  assign out_tlast  = out_last_r;

`include "serial_line_editor_top_assert.svh"

  `SLE_CHECK(a_done_is_last, out_valid_r && out_done_r, out_last_r, "line_done without last")
  `SLE_CHECK(a_idle_cnt_clear, state_r == S_IDLE, cnt_r == '0, "replay count not cleared")
  `SLE_CHECK(a_cursor_bound, 1'b1, cursor_r <= LAST_IDX, "cursor past capacity")
  `SLE_CHECK_NEXT(a_print_advance,
    rst_n && in_acc && state_nxt == S_PRINT,
    cursor_r == $past(cursor_r) + 1'b1, "printable did not advance cursor")

endmodule

`default_nettype wire
